// ===== src/tick_clock_with_segment_scan_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tick clock with segment scan
// Concurrent checks, compiled away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TICK_CLOCK_WITH_SEGMENT_SCAN_ASSERT_SVH
`define TICK_CLOCK_WITH_SEGMENT_SCAN_ASSERT_SVH
`ifndef SYNTHESIS
`define TCSS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TCSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TCSS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define TCSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/tcss_pkg.sv =====
// ----------------------------------------------------------------------------
// tcss_pkg
// Types, constants and digit helpers shared by the tick clock modules.
// ----------------------------------------------------------------------------
package tcss_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_SECOND = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TICKS   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LED_ENABLE       = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LED_STEADY       = 2'd3;

   localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd500;
   localparam logic [7:0]  DEBOUNCE_TICKS_RESET   = 8'd200;

   localparam logic [4:0] HOUR_LAST   = 5'd23;
   localparam logic [5:0] MINUTE_LAST = 6'd59;
   localparam logic [5:0] SECOND_LAST = 6'd59;

   localparam logic [7:0] DASH_PATTERN  = 8'h40;
   localparam logic [7:0] BLANK_PATTERN = 8'h00;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_HOUR,
      ACT_MINUTE,
      ACT_SECOND
   } tcss_act_type;

   typedef struct packed {
      logic hour;
      logic minute;
      logic second;
      logic sensor;
   } tcss_buttons_type;

   typedef struct packed {
      logic led;
      logic sensor;
   } tcss_ind_type;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
   } tcss_time_type;

   function automatic tcss_time_type tcss_bump_hour(tcss_time_type t);
      tcss_time_type r;
      r = t;
      r.hours = (t.hours >= HOUR_LAST) ? 5'd0 : t.hours + 5'd1;
      return r;
   endfunction

   function automatic tcss_time_type tcss_bump_minute(tcss_time_type t);
      tcss_time_type r;
      r = t;
      if (t.minutes >= MINUTE_LAST) begin
         r.minutes = 6'd0;
         r = tcss_bump_hour(r);
      end else begin
         r.minutes = t.minutes + 6'd1;
      end
      return r;
   endfunction

   function automatic tcss_time_type tcss_bump_second(tcss_time_type t);
      tcss_time_type r;
      r = t;
      if (t.seconds >= SECOND_LAST) begin
         r.seconds = 6'd0;
         r = tcss_bump_minute(r);
      end else begin
         r.seconds = t.seconds + 6'd1;
      end
      return r;
   endfunction

   function automatic logic [2:0] tcss_tens(logic [5:0] v);
      logic [2:0] d;
      if (v >= 6'd50)      d = 3'd5;
      else if (v >= 6'd40) d = 3'd4;
      else if (v >= 6'd30) d = 3'd3;
      else if (v >= 6'd20) d = 3'd2;
      else if (v >= 6'd10) d = 3'd1;
      else                 d = 3'd0;
      return d;
   endfunction

   function automatic logic [3:0] tcss_units(logic [5:0] v);
      logic [5:0] base;
      base = 6'(10 * tcss_tens(v));
      return 4'(v - base);
   endfunction

   function automatic logic [7:0] tcss_glyph(logic [3:0] d);
      logic [7:0] g;
      case (d)
         4'd0:    g = 8'h3f;
         4'd1:    g = 8'h06;
         4'd2:    g = 8'h5b;
         4'd3:    g = 8'h4f;
         4'd4:    g = 8'h66;
         4'd5:    g = 8'h6d;
         4'd6:    g = 8'h7d;
         4'd7:    g = 8'h07;
         4'd8:    g = 8'h7f;
         4'd9:    g = 8'h6f;
         default: g = BLANK_PATTERN;
      endcase
      return g;
   endfunction

endpackage

// ===== src/tcss_debounce.sv =====
// ----------------------------------------------------------------------------
// tcss_debounce
// Button hold-off, press arming and priority select, sensor and LED levels.
// ----------------------------------------------------------------------------
module tcss_debounce (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  tcss_pkg::tcss_buttons_type buttons,
   input  logic [7:0]                debounce_ticks,
   input  logic                      led_enable,
   input  logic                      led_steady,
   output tcss_pkg::tcss_act_type    act,
   output tcss_pkg::tcss_ind_type    ind_next
);
   import tcss_pkg::*;

   logic [7:0] holdoff_ff, holdoff_in, holdoff_step;
   logic       armed_ff, armed_in;
   logic       led_ff, led_in;
   logic       sensor_ff, sensor_in;
   logic       any_press;

   assign any_press = buttons.hour | buttons.minute | buttons.second | buttons.sensor;

   always_comb begin
      act          = ACT_NONE;
      holdoff_step = holdoff_ff;
      holdoff_in   = holdoff_ff;
      armed_in     = armed_ff;
      led_in       = led_ff;
      sensor_in    = sensor_ff;
      if (step) begin
         led_in = led_enable ? (led_steady ? 1'b1 : ~led_ff) : 1'b0;
         if (holdoff_ff < debounce_ticks) begin
            holdoff_step = holdoff_ff + 8'd1;
         end
         if (armed_ff) begin
            if (buttons.hour) begin
               act = ACT_HOUR;
            end else if (buttons.minute) begin
               act = ACT_MINUTE;
            end else if (buttons.second) begin
               act = ACT_SECOND;
            end else if (buttons.sensor) begin
               sensor_in = ~sensor_ff;
            end
            if (any_press) begin
               holdoff_step = 8'd0;
            end
         end
         holdoff_in = holdoff_step;
         armed_in   = any_press && (holdoff_step >= debounce_ticks);
      end
   end

   assign ind_next.led    = led_in;
   assign ind_next.sensor = sensor_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         holdoff_ff <= 8'd0;
         armed_ff   <= 1'b0;
         led_ff     <= 1'b0;
         sensor_ff  <= 1'b0;
      end else begin
         holdoff_ff <= holdoff_in;
         armed_ff   <= armed_in;
         led_ff     <= led_in;
         sensor_ff  <= sensor_in;
      end
   end

endmodule

// ===== src/tcss_timekeep.sv =====
// ----------------------------------------------------------------------------
// tcss_timekeep
// Tick prescaler and hours:minutes:seconds counters with button advance.
// ----------------------------------------------------------------------------
module tcss_timekeep (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [15:0]            ticks_per_second,
   input  tcss_pkg::tcss_act_type act,
   output tcss_pkg::tcss_time_type time_next,
   output logic                   redraw
);
   import tcss_pkg::*;

   logic [15:0]   tick_ff, tick_in, tick_inc;
   tcss_time_type time_ff, time_in, time_tick;
   logic          tick_hit;

   assign tick_inc = tick_ff + 16'd1;
   assign tick_hit = tick_inc >= ticks_per_second;

   always_comb begin
      tick_in   = tick_ff;
      time_tick = time_ff;
      time_in   = time_ff;
      redraw    = 1'b0;
      if (step) begin
         tick_in = tick_hit ? 16'd0 : tick_inc;
         if (tick_hit) begin
            time_tick = tcss_bump_second(time_ff);
         end
         case (act)
            ACT_HOUR:   time_in = tcss_bump_hour(time_tick);
            ACT_MINUTE: time_in = tcss_bump_minute(time_tick);
            ACT_SECOND: time_in = tcss_bump_second(time_tick);
            default:    time_in = time_tick;
         endcase
         redraw = tick_hit || (act != ACT_NONE);
      end
   end

   assign time_next = time_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= 16'd0;
         time_ff <= '0;
      end else begin
         tick_ff <= tick_in;
         time_ff <= time_in;
      end
   end

endmodule

// ===== src/tcss_display.sv =====
// ----------------------------------------------------------------------------
// tcss_display
// Eight-digit pattern store and scan position with active-low digit select.
// ----------------------------------------------------------------------------
module tcss_display (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    redraw,
   input  tcss_pkg::tcss_time_type time_next,
   output logic [7:0]              digit_select,
   output logic [7:0]              segment_pattern
);
   import tcss_pkg::*;

   logic [7:0] store_ff [8];
   logic [7:0] store_in [8];
   logic [2:0] scan_ff, scan_in, scan_adv;

   assign scan_adv        = scan_ff + 3'd1;
   assign digit_select    = ~(8'd1 << scan_adv);
   assign segment_pattern = store_ff[scan_adv];

   always_comb begin
      store_in = store_ff;
      scan_in  = scan_ff;
      if (step) begin
         scan_in = scan_adv;
         if (redraw) begin
            store_in[0] = tcss_glyph(tcss_units(time_next.seconds));
            store_in[1] = tcss_glyph({1'b0, tcss_tens(time_next.seconds)});
            store_in[2] = DASH_PATTERN;
            store_in[3] = tcss_glyph(tcss_units(time_next.minutes));
            store_in[4] = tcss_glyph({1'b0, tcss_tens(time_next.minutes)});
            store_in[5] = DASH_PATTERN;
            store_in[6] = tcss_glyph(tcss_units({1'b0, time_next.hours}));
            store_in[7] = tcss_glyph({1'b0, tcss_tens({1'b0, time_next.hours})});
            scan_in     = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= 3'd0;
         for (int i = 0; i < 8; i++) begin
            store_ff[i] <= BLANK_PATTERN;
         end
      end else begin
         scan_ff  <= scan_in;
         store_ff <= store_in;
      end
   end

endmodule

// ===== src/tick_clock_with_segment_scan.sv =====
// ----------------------------------------------------------------------------
// tick_clock_with_segment_scan
// Tick-driven hours:minutes:seconds clock with an eight-digit display scan.
// ----------------------------------------------------------------------------
// Each item on the req_ channel is one timer tick with four button levels.
// Each tick gives exactly one item on the rsp_ channel: the digit select and
// segment pattern to drive, the LED and sensor levels, and the clock time.
// An item accepted at one edge lands in the input register; once the output
// register is empty or not stalled, the item is worked in one pass and its
// result is loaded into the output register, which raises rsp_valid. One item
// per cycle is taken and delivered when rsp_stall stays low.
// While rsp_stall is high the result register holds its item, the input
// register holds one more, and req_stall rises until the result is taken.
// Reset clears the clock to 00:00:00, blanks the pattern store, drops any
// button arm and loads the register defaults (500 ticks per second, 200 ticks
// of hold-off, LED off). The csr_ port writes one register per enabled edge
// and the user must use it only while no item is in flight (not enforced).
// ----------------------------------------------------------------------------
`include "tick_clock_with_segment_scan_assert.svh"

module tick_clock_with_segment_scan (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_hour_button,
   input  logic                              req_minute_button,
   input  logic                              req_second_button,
   input  logic                              req_sensor_button,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_digit_select,
   output logic [7:0]                        rsp_segment_pattern,
   output logic                              rsp_led_out,
   output logic                              rsp_sensor_enable,
   output logic [4:0]                        rsp_hours,
   output logic [5:0]                        rsp_minutes,
   output logic [5:0]                        rsp_seconds,
   input  logic                              csr_write,
   input  logic [tcss_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tcss_pkg::CSR_DATA_W-1:0]   csr_data
);
   import tcss_pkg::*;

   logic [15:0]      tps_ff;
   logic [7:0]       debounce_ff;
   logic             led_enable_ff, led_steady_ff;

   logic             in_valid_ff;
   tcss_buttons_type in_buttons_ff;
   logic             step;

   tcss_act_type     act;
   tcss_ind_type     ind_next;
   tcss_time_type    time_next;
   logic             redraw;
   logic [7:0]       digit_select, segment_pattern;

   logic             rsp_valid_ff;

   assign step      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff        <= TICKS_PER_SECOND_RESET;
         debounce_ff   <= DEBOUNCE_TICKS_RESET;
         led_enable_ff <= 1'b0;
         led_steady_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TICKS_PER_SECOND: tps_ff        <= csr_data;
            CSR_DEBOUNCE_TICKS:   debounce_ff   <= csr_data[7:0];
            CSR_LED_ENABLE:       led_enable_ff <= csr_data[0];
            CSR_LED_STEADY:       led_steady_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_buttons_ff.hour   <= req_hour_button;
         in_buttons_ff.minute <= req_minute_button;
         in_buttons_ff.second <= req_second_button;
         in_buttons_ff.sensor <= req_sensor_button;
      end
   end

   tcss_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .buttons        (in_buttons_ff),
      .debounce_ticks (debounce_ff),
      .led_enable     (led_enable_ff),
      .led_steady     (led_steady_ff),
      .act            (act),
      .ind_next       (ind_next)
   );

   tcss_timekeep u_timekeep (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .ticks_per_second (tps_ff),
      .act              (act),
      .time_next        (time_next),
      .redraw           (redraw)
   );

   tcss_display u_display (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .redraw          (redraw),
      .time_next       (time_next),
      .digit_select    (digit_select),
      .segment_pattern (segment_pattern)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_digit_select    <= digit_select;
         rsp_segment_pattern <= segment_pattern;
         rsp_led_out         <= ind_next.led;
         rsp_sensor_enable   <= ind_next.sensor;
         rsp_hours           <= time_next.hours;
         rsp_minutes         <= time_next.minutes;
         rsp_seconds         <= time_next.seconds;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `TCSS_ASSERT_SAME(a_select_onehot, clock, reset, rsp_valid, $onehot(~rsp_digit_select), "digit select not one-hot low")
   `TCSS_ASSERT_SAME(a_time_range, clock, reset, rsp_valid, (rsp_hours <= HOUR_LAST) && (rsp_minutes <= MINUTE_LAST) && (rsp_seconds <= SECOND_LAST), "clock time out of range")
   `TCSS_ASSERT_NEXT(a_step_loads_rsp, clock, reset, step, rsp_valid_ff, "worked item missing from result register")
   `TCSS_ASSERT_SAME(a_stall_has_item, clock, reset, req_stall, in_valid_ff, "input stalled with empty input register")

endmodule
